[hw/rtl/assert_macros.svh]
// Assertion helper macros for the RTL folder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Condition that must hold on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_ALWAYS(label, clk, rst, cond)
`endif
`endif

[hw/rtl/kcache_pkg.sv]
// ----------------------------------------------------------------------------
// kcache_pkg
// Shared types, codes and defaults for the keyed tile cache.
// ----------------------------------------------------------------------------
package kcache_pkg;

  localparam int DefCapacity   = 64;
  localparam int DefCoordBits  = 16;
  localparam int TimeBits      = 48;
  localparam int CfgDataBits   = 32;
  localparam int CfgIdxBits    = 2;
  localparam int SlotBits      = 6;
  localparam int CountBits     = 7;

  localparam logic [31:0] ResetCleanupPeriod = 32'd1000000;
  localparam logic [6:0]  ResetMaxEntries    = 7'd48;
  localparam logic [31:0] ResetMinResidency  = 32'd5000000;

  // register indexes
  localparam logic [CfgIdxBits-1:0] RegCleanupPeriod = 2'd0;
  localparam logic [CfgIdxBits-1:0] RegMaxEntries    = 2'd1;
  localparam logic [CfgIdxBits-1:0] RegMinResidency  = 2'd2;

  // result kinds
  localparam logic [1:0] KindHit     = 2'd0;
  localparam logic [1:0] KindInsert  = 2'd1;
  localparam logic [1:0] KindFull    = 2'd2;
  localparam logic [1:0] KindEvict   = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY,
    ST_EMIT_ACC,
    ST_CHECK,
    ST_MIN_SCAN,
    ST_MIN_DONE,
    ST_EMIT_EV
  } kc_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture input word
    logic scan_clr;   // reset scan state
    logic scan_step;  // process one slot
    logic apply;      // update table with access result
    logic cleanup;    // record cleanup time, latch excess
    logic evict;      // drop the chosen slot
    logic emit_acc;   // load output with access word
    logic emit_ev;    // load output with eviction word
    logic emit_last;  // last flag for the emitted word
  } kc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;
    logic do_cleanup;
    logic need_evict;  // count above limit after access
    logic min_ok;      // a candidate exists and is old enough
    logic more_evict;  // another eviction follows this one
    logic first_pass;  // no eviction done yet in this pass
  } kc_stat_t;

endpackage

[hw/rtl/kcache_ctrl.sv]
// ----------------------------------------------------------------------------
// kcache_ctrl
// Sequencer: slot scan, table update, cleanup check and eviction loop.
// ----------------------------------------------------------------------------
module kcache_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               out_free,
  input  kcache_pkg::kc_stat_t stat,
  output kcache_pkg::kc_cmd_t  cmd
);
  import kcache_pkg::*;

  kc_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // next state; the oldest entry is found before the access word leaves,
  // so the last flag of every word is known when it is emitted
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (in_valid) state_next = ST_SCAN;
      ST_SCAN:     if (stat.scan_done) state_next = ST_APPLY;
      ST_APPLY:    state_next = ST_CHECK;
      ST_CHECK:    state_next = (stat.do_cleanup && stat.need_evict) ? ST_MIN_SCAN
                                                                     : ST_EMIT_ACC;
      ST_EMIT_ACC: if (out_free) state_next = stat.min_ok ? ST_EMIT_EV : ST_IDLE;
      ST_MIN_SCAN: if (stat.scan_done) state_next = ST_MIN_DONE;
      ST_MIN_DONE: state_next = stat.first_pass ? ST_EMIT_ACC : ST_EMIT_EV;
      ST_EMIT_EV:  if (out_free) state_next = stat.more_evict ? ST_MIN_SCAN : ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
        cmd.scan_clr = in_valid;
      end
      ST_SCAN:  cmd.scan_step = 1'b1;
      ST_APPLY: cmd.apply = 1'b1;
      ST_CHECK: begin
        cmd.cleanup = stat.do_cleanup;
        cmd.scan_clr = 1'b1;
      end
      ST_EMIT_ACC: if (out_free) begin
        cmd.emit_acc = 1'b1;
        cmd.emit_last = !stat.min_ok;
      end
      ST_MIN_SCAN: cmd.scan_step = 1'b1;
      ST_MIN_DONE: ;
      ST_EMIT_EV: if (out_free) begin
        cmd.emit_ev = 1'b1;
        cmd.evict = 1'b1;
        cmd.emit_last = !stat.more_evict;
        cmd.scan_clr = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

[hw/rtl/kcache_dp.sv]
// ----------------------------------------------------------------------------
// kcache_dp
// Table storage, one-slot-per-cycle scan, counters and output register.
// ----------------------------------------------------------------------------
module kcache_dp #(
  parameter int CAPACITY   = kcache_pkg::DefCapacity,
  parameter int COORD_BITS = kcache_pkg::DefCoordBits
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [31:0]                   cleanup_period,
  input  logic [6:0]                    max_entries,
  input  logic [31:0]                   minimum_residency,
  input  logic signed [COORD_BITS-1:0]  tile_x,
  input  logic signed [COORD_BITS-1:0]  tile_y,
  input  logic [kcache_pkg::TimeBits-1:0] time_now,
  input  kcache_pkg::kc_cmd_t           cmd,
  output kcache_pkg::kc_stat_t          stat,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic [1:0]                    kind,
  output logic [5:0]                    slot,
  output logic signed [COORD_BITS-1:0]  key_x,
  output logic signed [COORD_BITS-1:0]  key_y,
  output logic                          last
);
  import kcache_pkg::*;

  localparam int IdxBits = $clog2(CAPACITY);
  localparam int CntBits = $clog2(CAPACITY + 1);
  localparam logic [IdxBits-1:0] LastIdx = IdxBits'(CAPACITY - 1);

  // entry memories
  logic [CAPACITY-1:0]        valid;
  logic [COORD_BITS-1:0]      mem_x [CAPACITY];
  logic [COORD_BITS-1:0]      mem_y [CAPACITY];
  logic [TimeBits-1:0]        mem_t [CAPACITY];
  logic [COORD_BITS-1:0]      rd_x, rd_y;
  logic [TimeBits-1:0]        rd_t;

  logic [COORD_BITS-1:0]      req_x, req_y;
  logic [TimeBits-1:0]        req_t, last_cleanup;
  logic [IdxBits-1:0]         ptr, rd_idx;
  logic                       rd_live, scan_end;
  logic                       hit_f, free_f;
  logic [IdxBits-1:0]         hit_idx, free_idx;
  logic [CntBits-1:0]         count, excess, released;
  logic                       best_f;
  logic [IdxBits-1:0]         best_idx;
  logic [TimeBits-1:0]        best_t;
  logic [COORD_BITS-1:0]      best_x, best_y;
  logic                       sec_f;
  logic [TimeBits-1:0]        sec_t;
  logic [1:0]                 acc_kind;
  logic [IdxBits-1:0]         acc_slot;
  logic [CntBits-1:0]         limit;
  logic [TimeBits-1:0]        elapsed, age, sec_age;
  logic                       wr_en;
  logic [IdxBits-1:0]         wr_idx;

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_x[wr_idx] <= req_x;
      mem_y[wr_idx] <= req_y;
      mem_t[wr_idx] <= req_t;
    end
    rd_x <= mem_x[ptr];
    rd_y <= mem_y[ptr];
    rd_t <= mem_t[ptr];
  end

  // table write on apply: refresh a hit or fill a free slot
  always_comb begin
    wr_en  = cmd.apply && (hit_f || free_f);
    wr_idx = hit_f ? hit_idx : free_idx;
  end

  // capture request
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_x <= tile_x;
      req_y <= tile_y;
      req_t <= time_now;
    end
  end

  // scan pointer; registered read data trails the pointer
  always_ff @(posedge clk) begin
    if (rst || cmd.scan_clr) begin
      ptr <= '0; rd_live <= 1'b0; scan_end <= 1'b0;
    end else if (cmd.scan_step) begin
      rd_idx  <= ptr;
      rd_live <= !scan_end;
      if (ptr == LastIdx) scan_end <= 1'b1;
      else ptr <= ptr + 1'b1;
    end
  end
  assign stat.scan_done = scan_end && !rd_live && cmd.scan_step;

  // lookup, first free slot and search for the oldest and second oldest entry
  always_ff @(posedge clk) begin
    if (rst || cmd.scan_clr) begin
      hit_f <= 1'b0; free_f <= 1'b0; best_f <= 1'b0; sec_f <= 1'b0;
      hit_idx <= '0; free_idx <= '0;
    end else if (cmd.scan_step && rd_live) begin
      if (valid[rd_idx]) begin
        if (!hit_f && rd_x == req_x && rd_y == req_y) begin
          hit_f <= 1'b1; hit_idx <= rd_idx;
        end
        if (!best_f || rd_t < best_t) begin
          best_f <= 1'b1; best_idx <= rd_idx; best_t <= rd_t;
          best_x <= rd_x; best_y <= rd_y;
          sec_f <= best_f; sec_t <= best_t;
        end else if (!sec_f || rd_t < sec_t) begin
          sec_f <= 1'b1; sec_t <= rd_t;
        end
      end else if (!free_f) begin
        free_f <= 1'b1; free_idx <= rd_idx;
      end
    end
  end

  // valid bits and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0; count <= '0;
    end else if (cmd.apply && !hit_f && free_f) begin
      valid[free_idx] <= 1'b1; count <= count + 1'b1;
    end else if (cmd.evict) begin
      valid[best_idx] <= 1'b0; count <= count - 1'b1;
    end
  end

  // access result
  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      acc_kind <= hit_f ? KindHit : (free_f ? KindInsert : KindFull);
      acc_slot <= hit_f ? hit_idx : (free_f ? free_idx : '0);
    end
  end

  // cleanup decision
  assign elapsed = (req_t >= last_cleanup) ? req_t - last_cleanup : '0;
  assign stat.do_cleanup = elapsed > TimeBits'(cleanup_period);
  assign limit = (max_entries == 7'd0) ? CntBits'(1) :
                 (max_entries > 7'(CAPACITY) ? CntBits'(CAPACITY) : CntBits'(max_entries));
  assign stat.need_evict = count > limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_cleanup <= '0; released <= '0; excess <= '0;
    end else if (cmd.cleanup) begin
      last_cleanup <= req_t;
      released <= '0;
      excess <= count - limit;
    end else if (cmd.evict) begin
      released <= released + 1'b1;
    end
  end

  // the second oldest is the next candidate once the oldest is dropped
  assign age     = (req_t >= best_t) ? req_t - best_t : '0;
  assign sec_age = (req_t >= sec_t) ? req_t - sec_t : '0;
  assign stat.min_ok = best_f && !(age < TimeBits'(minimum_residency));
  assign stat.more_evict = ((released + 1'b1) < excess) && sec_f &&
                           !(sec_age < TimeBits'(minimum_residency));
  assign stat.first_pass = (released == '0);

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.emit_acc || cmd.emit_ev) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (cmd.emit_acc) begin
      kind <= acc_kind; slot <= 6'(acc_slot);
      key_x <= req_x; key_y <= req_y; last <= cmd.emit_last;
    end else if (cmd.emit_ev) begin
      kind <= KindEvict; slot <= 6'(best_idx);
      key_x <= best_x; key_y <= best_y; last <= cmd.emit_last;
    end
  end

endmodule

[hw/rtl/keyed_cache_with_aged_eviction_unit.sv]
// ----------------------------------------------------------------------------
// keyed_cache_with_aged_eviction_unit
// Tile cache keyed by signed (x,y) with periodic oldest-first eviction.
// ----------------------------------------------------------------------------
// One access at a time. A lookup walks all CAPACITY slots through the entry
// memory, one slot per cycle; the table is then updated and the cleanup is
// checked before the first result word is loaded into the output register.
// When a cleanup pass has to evict, the table is walked once more for the
// oldest entry before the access word leaves, and each eviction word after
// the first costs another walk. Output stalls hold each result word back
// until the output register is free. The input is stalled from acceptance
// until the last word has been handed to the output register.
`include "assert_macros.svh"
module keyed_cache_with_aged_eviction_unit #(
  parameter int CAPACITY   = kcache_pkg::DefCapacity,
  parameter int COORD_BITS = kcache_pkg::DefCoordBits
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [kcache_pkg::CfgIdxBits-1:0] cfg_index,
  input  logic [kcache_pkg::CfgDataBits-1:0] cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] tile_x,
  input  logic signed [COORD_BITS-1:0] tile_y,
  input  logic [kcache_pkg::TimeBits-1:0] time_now,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   kind,
  output logic [5:0]                   slot,
  output logic signed [COORD_BITS-1:0] key_x,
  output logic signed [COORD_BITS-1:0] key_y,
  output logic                         last
);
  import kcache_pkg::*;

  logic [31:0] cleanup_period, minimum_residency;
  logic [6:0]  max_entries;
  kc_cmd_t     cmd;
  kc_stat_t    stat;
  logic        out_free;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cleanup_period    <= ResetCleanupPeriod;
      max_entries       <= ResetMaxEntries;
      minimum_residency <= ResetMinResidency;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegCleanupPeriod: cleanup_period    <= cfg_data;
        RegMaxEntries:    max_entries       <= cfg_data[6:0];
        RegMinResidency:  minimum_residency <= cfg_data;
        default: ;
      endcase
    end
  end

  assign out_free = !out_valid || !out_stall;

  kcache_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_free, .stat, .cmd
  );

  kcache_dp #(.CAPACITY(CAPACITY), .COORD_BITS(COORD_BITS)) u_dp (
    .clk, .rst, .cleanup_period, .max_entries,
    .minimum_residency, .tile_x, .tile_y, .time_now, .cmd, .stat,
    .out_stall, .out_valid, .kind, .slot, .key_x, .key_y, .last
  );

  `ASSERT_IMPL(a_no_emit_busy, clk, rst, cmd.emit_acc || cmd.emit_ev, out_free)
  `ASSERT_ALWAYS(a_one_emit, clk, rst, !(cmd.emit_acc && cmd.emit_ev))
  `ASSERT_IMPL(a_full_slot, clk, rst, out_valid && kind == KindFull, slot == 6'd0)

endmodule
